[rtl/adaptive_cumulative_frequency_model_macros.svh]
// Assertion macros shared by the frequency model RTL.
// No dependencies; the using module must provide clk and rst_n.
`ifndef ADAPTIVE_CUMULATIVE_FREQUENCY_MODEL_MACROS_SVH
`define ADAPTIVE_CUMULATIVE_FREQUENCY_MODEL_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define ACFM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define ACFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/acfm_pkg.sv]
// Shared types, codes and constants for the adaptive cumulative frequency model.
// No dependencies; used by acfm_ctrl, acfm_dp and the top level.
package acfm_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;

  localparam int NUM_W      = 9;
  localparam int INC_W      = 11;
  localparam int LIM_W      = 16;
  localparam int CNT_W      = 16;
  localparam int SYM_W      = 8;
  localparam int FUNC_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;   // symbol, target
  localparam int OUT_DATA_W = 56;   // coded_symbol, low, high, total

  localparam logic [NUM_W-1:0] NUM_SYMBOLS_RST   = 9'd256;
  localparam logic [INC_W-1:0] INCREMENT_RST     = 11'd1;
  localparam logic [LIM_W-1:0] RESCALE_LIMIT_RST = 16'd8192;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENCODE  = 2'd0,
    FUNC_DECODE  = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_SYMBOLS   = 2'd0,
    REG_INCREMENT     = 2'd1,
    REG_RESCALE_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_RESULT
  } state_t;

  // What an incoming request needs from the controller
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RESULT,
    KIND_SWEEP
  } kind_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  last_addr;
  } status_t;

endpackage

[rtl/acfm_ctrl.sv]
// Sequencing state machine for the frequency model: accept, sweep, drain, result.
// Depends on acfm_pkg and adaptive_cumulative_frequency_model_macros.svh.
`include "adaptive_cumulative_frequency_model_macros.svh"

module acfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  acfm_pkg::status_t st,
  output acfm_pkg::cmd_t    cmd
);

  acfm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == acfm_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acfm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      acfm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          unique case (st.kind)
            acfm_pkg::KIND_SWEEP:  state_nxt = acfm_pkg::S_SWEEP;
            acfm_pkg::KIND_RESULT: state_nxt = acfm_pkg::S_RESULT;
            default:               state_nxt = acfm_pkg::S_IDLE;
          endcase
        end
      end
      acfm_pkg::S_SWEEP: begin
        cmd.issue = 1'b1;
        if (st.last_addr) begin
          state_nxt = acfm_pkg::S_DRAIN;
        end
      end
      acfm_pkg::S_DRAIN: begin
        state_nxt = acfm_pkg::S_RESULT;
      end
      acfm_pkg::S_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = acfm_pkg::S_IDLE;
        end
      end
      default: state_nxt = acfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  `ACFM_ASSERT(a_load_into_free, cmd.load_out, !out_valid_r || out_tready, "result overwrote a pending one")

endmodule

[rtl/acfm_dp.sv]
// Datapath: config registers, cumulative count memory, sweep pipeline, result regs.
// Depends on acfm_pkg and adaptive_cumulative_frequency_model_macros.svh.
`include "adaptive_cumulative_frequency_model_macros.svh"

module acfm_dp #(
  parameter int MAX_SYMBOLS = acfm_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acfm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [acfm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [acfm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [acfm_pkg::FUNC_W-1:0]         in_tuser,
  input  acfm_pkg::cmd_t                      cmd,
  output acfm_pkg::status_t                   st,
  output logic [acfm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);

  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int NW    = (CW > acfm_pkg::NUM_W) ? CW : acfm_pkg::NUM_W;
  localparam int DEPTH = MAX_SYMBOLS + 1;
  localparam int NRST  = (int'(acfm_pkg::NUM_SYMBOLS_RST) > MAX_SYMBOLS) ?
                         MAX_SYMBOLS : int'(acfm_pkg::NUM_SYMBOLS_RST);

  // config
  logic [acfm_pkg::NUM_W-1:0] num_r;
  logic [acfm_pkg::INC_W-1:0] inc_r;
  logic [acfm_pkg::LIM_W-1:0] lim_r;

  // model state
  logic [acfm_pkg::CNT_W-1:0] total_r, total_nxt;
  logic [CW-1:0]              w_r, w_nxt;      // highest entry written since the last reinit
  logic [acfm_pkg::CNT_W-1:0] tbl_mem [DEPTH];

  // sweep
  logic [CW-1:0]              k_r;             // read address
  logic [CW-1:0]              pk_r;            // entry whose data is in rd_q
  logic                       pv_r;
  logic [acfm_pkg::CNT_W-1:0] rd_q;
  logic                       dec_r;
  logic                       resc_r;
  logic                       passed_r;
  logic [acfm_pkg::SYM_W-1:0] sym_r;
  logic [acfm_pkg::CNT_W-1:0] tgt_r;
  logic [acfm_pkg::CNT_W-1:0] lo_r;
  logic [acfm_pkg::CNT_W-1:0] prev_r;

  // result
  logic [acfm_pkg::SYM_W-1:0]      res_sym_r;
  logic [acfm_pkg::CNT_W-1:0]      res_low_r;
  logic [acfm_pkg::CNT_W-1:0]      res_high_r;
  logic [acfm_pkg::CNT_W-1:0]      res_total_r;
  logic                            res_err_r;
  logic [acfm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_err_r;

  logic [acfm_pkg::SYM_W-1:0] in_sym;
  logic [acfm_pkg::CNT_W-1:0] in_tgt;
  logic [CW-1:0]              n_c;
  logic                       enc_err;
  logic                       dec_err;
  logic [acfm_pkg::CNT_W:0]   sum_inc;
  logic [acfm_pkg::CNT_W-1:0] old_val;
  logic                       cap;
  logic                       add_en;
  logic [acfm_pkg::CNT_W:0]   new_val;
  logic [acfm_pkg::CNT_W-1:0] halved;
  logic [acfm_pkg::CNT_W-1:0] bumped;
  logic [acfm_pkg::CNT_W-1:0] wr_data;
  logic                       last_proc;
  logic                       restart;

  assign in_sym = in_tdata[acfm_pkg::SYM_W-1:0];
  assign in_tgt = in_tdata[acfm_pkg::IN_DATA_W-1:acfm_pkg::SYM_W];

  // alphabet size clamped to 1..MAX_SYMBOLS
  always_comb begin
    if (num_r == '0) begin
      n_c = CW'(1);
    end else if (NW'(num_r) > NW'(MAX_SYMBOLS)) begin
      n_c = CW'(MAX_SYMBOLS);
    end else begin
      n_c = CW'(num_r);
    end
  end

  assign enc_err = NW'(in_sym) >= NW'(n_c);
  assign dec_err = in_tgt >= total_r;
  assign sum_inc = {1'b0, total_r} + (acfm_pkg::CNT_W + 1)'(inc_r);

  always_comb begin
    st.kind      = acfm_pkg::KIND_NONE;
    st.last_addr = (k_r == n_c);
    restart      = 1'b0;
    unique case (in_tuser)
      acfm_pkg::FUNC_ENCODE:  st.kind = enc_err ? acfm_pkg::KIND_RESULT : acfm_pkg::KIND_SWEEP;
      acfm_pkg::FUNC_DECODE:  st.kind = dec_err ? acfm_pkg::KIND_RESULT : acfm_pkg::KIND_SWEEP;
      acfm_pkg::FUNC_RESTART: restart = 1'b1;
      default:                st.kind = acfm_pkg::KIND_NONE;
    endcase
  end

  // entries beyond the written prefix read as their initial value i
  assign old_val = (pk_r > w_r) ? acfm_pkg::CNT_W'(pk_r) : rd_q;

  // first entry above the symbol: decode finds it by target, encode by index
  assign cap = !passed_r &&
               (dec_r ? (old_val > tgt_r) : (NW'(pk_r) == NW'(sym_r) + NW'(1)));
  assign add_en = passed_r || cap;
  assign new_val = {1'b0, old_val} +
                   (add_en ? (acfm_pkg::CNT_W + 1)'(inc_r) : '0);
  assign halved  = new_val[acfm_pkg::CNT_W:1];
  assign bumped  = (lo_r >= halved) ? lo_r + acfm_pkg::CNT_W'(1) : halved;
  assign wr_data = resc_r ? bumped : new_val[acfm_pkg::CNT_W-1:0];
  assign last_proc = pv_r && (pk_r == n_c);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= acfm_pkg::NUM_SYMBOLS_RST;
      inc_r <= acfm_pkg::INCREMENT_RST;
      lim_r <= acfm_pkg::RESCALE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acfm_pkg::REG_NUM_SYMBOLS:   num_r <= cfg_wdata[acfm_pkg::NUM_W-1:0];
        acfm_pkg::REG_INCREMENT:     inc_r <= cfg_wdata[acfm_pkg::INC_W-1:0];
        acfm_pkg::REG_RESCALE_LIMIT: lim_r <= cfg_wdata[acfm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // total and written prefix: reinit on alphabet write or restart,
  // take the new top entry at the end of a sweep
  always_comb begin
    total_nxt = total_r;
    w_nxt     = w_r;
    if (cfg_we && (cfg_addr == acfm_pkg::REG_NUM_SYMBOLS)) begin
      if (cfg_wdata[acfm_pkg::NUM_W-1:0] == '0) begin
        total_nxt = acfm_pkg::CNT_W'(1);
      end else if (NW'(cfg_wdata[acfm_pkg::NUM_W-1:0]) > NW'(MAX_SYMBOLS)) begin
        total_nxt = acfm_pkg::CNT_W'(MAX_SYMBOLS);
      end else begin
        total_nxt = acfm_pkg::CNT_W'(cfg_wdata[acfm_pkg::NUM_W-1:0]);
      end
      w_nxt = '0;
    end else if (cmd.accept && restart) begin
      total_nxt = acfm_pkg::CNT_W'(n_c);
      w_nxt     = '0;
    end else if (last_proc) begin
      total_nxt = wr_data;
      w_nxt     = pk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= acfm_pkg::CNT_W'(NRST);
      w_r      <= '0;
      pv_r     <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      w_r     <= w_nxt;
      pv_r    <= cmd.issue;
      if (cmd.accept) begin
        passed_r <= 1'b0;
      end else if (pv_r && cap) begin
        passed_r <= 1'b1;
      end
    end
  end

  // sweep payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k_r         <= CW'(1);
      lo_r        <= '0;
      prev_r      <= '0;
      sym_r       <= in_sym;
      tgt_r       <= in_tgt;
      dec_r       <= (in_tuser == acfm_pkg::FUNC_DECODE);
      resc_r      <= sum_inc > (acfm_pkg::CNT_W + 1)'(lim_r);
      res_total_r <= total_r;
      res_low_r   <= '0;
      res_high_r  <= '0;
      res_sym_r   <= (in_tuser == acfm_pkg::FUNC_ENCODE) ? in_sym : '0;
      res_err_r   <= (in_tuser == acfm_pkg::FUNC_ENCODE) ? enc_err : dec_err;
    end else begin
      if (cmd.issue) begin
        k_r  <= k_r + CW'(1);
        pk_r <= k_r;
      end
      if (pv_r) begin
        lo_r   <= bumped;
        prev_r <= old_val;
        if (cap) begin
          res_sym_r  <= acfm_pkg::SYM_W'(CW'(pk_r - CW'(1)));
          res_low_r  <= prev_r;
          res_high_r <= old_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r) begin
      tbl_mem[pk_r] <= wr_data;
    end
    if (cmd.issue) begin
      rd_q <= tbl_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {res_total_r, res_high_r, res_low_r, res_sym_r};
      out_err_r  <= res_err_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_err_r;

  `ACFM_ASSERT(a_pk_range, pv_r, (pk_r != '0) && (pk_r <= n_c), "sweep entry out of range")
  `ACFM_ASSERT(a_dec_found, pv_r && dec_r && (pk_r == n_c), passed_r || cap, "decode search missed")
  `ACFM_ASSERT(a_rescale_mono, pv_r && resc_r, wr_data > lo_r, "rescaled bounds not increasing")

endmodule

[rtl/adaptive_cumulative_frequency_model.sv]
// Top level of the adaptive cumulative frequency model for an arithmetic coder.
// Depends on acfm_pkg, acfm_ctrl and acfm_dp.
//
// Channel | Direction | Handshake         | Payload
// --------+-----------+-------------------+------------------------------------------
// in_     | slave     | tvalid / tready   | tdata: symbol, target; tuser: func
// out_    | master    | tvalid / tready   | tdata: symbol, low, high, total; tuser: err
// cfg_    | write     | cfg_we only       | cfg_addr index, cfg_wdata value
//
// An encode or decode request that adapts the model makes one pass, n being the active
// alphabet size, over cumulative entries 1..n through the one-read, one-write table
// memory, read, update and write back one entry per cycle.
// A request with a range error skips the sweep; restart and unused codes give no result.
// Reset is synchronous; the table needs no clearing pass, a written-prefix mark
// makes untouched entries read as their initial value.
// The result register lets a new request in while the last result is unclaimed;
// a finished sweep holds in its result state until the output register frees.

module adaptive_cumulative_frequency_model #(
  parameter int MAX_SYMBOLS = acfm_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [acfm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [acfm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [acfm_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] symbol, [23:8] target
  input  logic [acfm_pkg::FUNC_W-1:0]         in_tuser,   // [1:0] func
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [acfm_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] coded_symbol,
                                                          // [23:8] low_bound,
                                                          // [39:24] high_bound,
                                                          // [55:40] total_count
  output logic                                out_tuser   // [0] range_error
);

  acfm_pkg::cmd_t    cmd;
  acfm_pkg::status_t st;

  // Controller: owns the request handshake, the sweep sequencing and the
  // output valid flag.
  acfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // Datapath: config registers, running total, table memory and the
  // read-modify-write pipeline that applies increment and halving together.
  acfm_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
